>>> hdl/apf_pkg.sv
// Shared types and constants for the articulation point finder.
// No dependencies; imported by apf_ram and articulation_point_finder.
package apf_pkg;

    localparam int MAX_VERTICES_DEF = 1024;
    localparam int MAX_EDGES_DEF    = 4096;
    localparam int VID_W            = 11;
    localparam logic [VID_W-1:0] VCOUNT_RST = 11'd1024;

    typedef enum logic [1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_RUN   = 2'd1,
        FUNC_QUERY = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_RANGE  = 2'd2,
        ST_NOCALC = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DEC,
        S_ADD1,
        S_ADD2,
        S_ADD3,
        S_QRD,
        S_CLR,
        S_RROOT,
        S_RCHK,
        S_STEP,
        S_ARC,
        S_VISIT,
        S_RCUT,
        S_POP,
        S_DONE
    } state_t;

endpackage

>>> hdl/apf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on apf_pkg only for the common import style.
module apf_ram
    import apf_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/articulation_point_finder.sv
// Articulation point finder: arc store, iterative DFS sequencer, query port.
// Depends on apf_pkg and apf_ram.
//
// Usage: items arrive on s_tvalid/s_tready with the operation in s_tuser
// (0 add edge, 1 run search, 2 query) and the two vertices in s_tdata.
// Every transaction yields one result on m_tvalid/m_tready: status in
// m_tuser, cut flag and cut count in m_tdata. The user writes vertex_count through
// cfg_wen/cfg_wdata only while the block is idle; the block does not enforce it.
// One item is handled at a time; s_tready is high only in the idle state.
// An add edge passes decode, the add states and done; a query decode, read and done;
// a rejected add or query and other codes decode and done; then idle takes the next item.
// Run search: decode and the clearing state for every vertex slot, then the root
// read and check states per root candidate, the step and arc states per arc walked
// plus the visit state when its target is in range, and the step state and the pop
// or root-cut state per vertex when it is finished; one read per memory per cycle.
// After reset the list heads are cleared slot by slot in the init state, during
// which no item is taken (configuration writes still are).
// A stalled receiver holds the result in the output register; the block still returns
// to idle and takes the next item, then waits in done with its result until drained.
module articulation_point_finder
    import apf_pkg::*;
#(
    parameter int MAX_VERTICES = MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = MAX_EDGES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // vertex_a[10:0], vertex_b[21:11], zero pad
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // is_cut[0], cut_count[11:1], zero pad
    output logic [1:0]  m_tuser,   // status[1:0]
    input  logic        cfg_wen,
    input  logic [10:0] cfg_wdata  // vertex_count
);

    localparam int ARC_CAP = 2 * MAX_EDGES;
    localparam int VAW     = $clog2(MAX_VERTICES);
    localparam int AIW     = $clog2(ARC_CAP);
    localparam int PW      = $clog2(ARC_CAP + 1);
    localparam int SPW     = $clog2(MAX_VERTICES + 1);
    localparam int SWW     = 3 * VID_W + PW;

    state_t state_reg, state_next;

    logic [VID_W-1:0] vc_reg;
    logic [1:0]       func_reg;
    logic [VID_W-1:0] va_reg, vb_reg;
    logic [PW-1:0]    used_reg;
    logic             res_valid_reg;
    logic [VID_W-1:0] time_reg, total_reg;
    logic [VAW-1:0]   idx_reg;
    logic [VID_W:0]   root_reg;
    logic [VID_W-1:0] cur_v_reg, cur_p_reg, cur_ch_reg, cur_low_reg, child_low_reg;
    logic [PW-1:0]    cur_a_reg;
    logic [VID_W-1:0] tgt_reg;
    logic [SPW-1:0]   sp_reg;
    logic [1:0]       status_reg;
    logic             iscut_reg;
    logic [VID_W-1:0] count_reg;
    logic             m_valid_reg;
    logic [1:0]       m_status_reg;
    logic             m_cut_reg;
    logic [VID_W-1:0] m_count_reg;

    // memory ports
    logic             head_we;
    logic [VAW-1:0]   head_waddr, head_raddr;
    logic [PW-1:0]    head_wdata, head_rdata;
    logic             arc_we;
    logic [AIW-1:0]   arc_waddr, arc_raddr;
    logic [PW-1:0]    next_wdata, next_rdata;
    logic [VID_W-1:0] tgt_wdata, tgt_rdata;
    logic             disc_we;
    logic [VAW-1:0]   disc_waddr, disc_raddr;
    logic [VID_W-1:0] disc_wdata, disc_rdata;
    logic             low_we;
    logic [VAW-1:0]   low_waddr, low_raddr;
    logic [VID_W-1:0] low_wdata, low_rdata;
    logic             cut_we;
    logic [VAW-1:0]   cut_waddr, cut_raddr;
    logic             cut_wdata, cut_rdata;
    logic             stk_we;
    logic [VAW-1:0]   stk_waddr, stk_raddr;
    logic [SWW-1:0]   stk_wdata, stk_rdata;

    logic [VID_W-1:0] eff_cnt;
    logic             ok_a, ok_b, arc_full, have_arc, tgt_ok, mark_pop, mark_root;
    logic [VID_W-1:0] ent_v, ent_p, ent_ch;
    logic [PW-1:0]    ent_a;
    logic [VID_W-1:0] t_next;

    function automatic logic [VAW-1:0] vidx(input logic [VID_W-1:0] v);
        logic [VID_W-1:0] d;
        d = v - 1'b1;
        return VAW'(d);
    endfunction

    assign eff_cnt  = (32'(vc_reg) > MAX_VERTICES) ? VID_W'(MAX_VERTICES) : vc_reg;
    assign ok_a     = (va_reg != '0) && (va_reg <= eff_cnt);
    assign ok_b     = (vb_reg != '0) && (vb_reg <= eff_cnt);
    assign arc_full = (PW'(ARC_CAP) - used_reg) < PW'(2);
    assign have_arc = (cur_a_reg != '0) && (cur_a_reg <= PW'(ARC_CAP));
    assign tgt_ok   = (tgt_rdata != '0) && (tgt_rdata <= eff_cnt);
    assign t_next   = time_reg + 1'b1;

    assign ent_v  = stk_rdata[SWW-1 -: VID_W];
    assign ent_p  = stk_rdata[SWW-VID_W-1 -: VID_W];
    assign ent_a  = stk_rdata[VID_W +: PW];
    assign ent_ch = stk_rdata[VID_W-1:0];

    // cut test when a child pops back to its non-root parent (ent_v)
    assign mark_pop  = (ent_p != '0) && (child_low_reg >= disc_rdata) && !cut_rdata;
    assign mark_root = (cur_ch_reg > VID_W'(1)) && !cut_rdata;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {4'b0, m_count_reg, m_cut_reg};

    apf_ram #(.WIDTH(PW), .DEPTH(MAX_VERTICES)) u_head (
        .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .raddr(head_raddr), .rdata(head_rdata));
    apf_ram #(.WIDTH(PW), .DEPTH(ARC_CAP)) u_next (
        .clk(clk), .we(arc_we), .waddr(arc_waddr), .wdata(next_wdata),
        .raddr(arc_raddr), .rdata(next_rdata));
    apf_ram #(.WIDTH(VID_W), .DEPTH(ARC_CAP)) u_tgt (
        .clk(clk), .we(arc_we), .waddr(arc_waddr), .wdata(tgt_wdata),
        .raddr(arc_raddr), .rdata(tgt_rdata));
    apf_ram #(.WIDTH(VID_W), .DEPTH(MAX_VERTICES)) u_disc (
        .clk(clk), .we(disc_we), .waddr(disc_waddr), .wdata(disc_wdata),
        .raddr(disc_raddr), .rdata(disc_rdata));
    apf_ram #(.WIDTH(VID_W), .DEPTH(MAX_VERTICES)) u_low (
        .clk(clk), .we(low_we), .waddr(low_waddr), .wdata(low_wdata),
        .raddr(low_raddr), .rdata(low_rdata));
    apf_ram #(.WIDTH(1), .DEPTH(MAX_VERTICES)) u_cut (
        .clk(clk), .we(cut_we), .waddr(cut_waddr), .wdata(cut_wdata),
        .raddr(cut_raddr), .rdata(cut_rdata));
    apf_ram #(.WIDTH(SWW), .DEPTH(MAX_VERTICES)) u_stk (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .raddr(stk_raddr), .rdata(stk_rdata));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:  if (idx_reg == VAW'(MAX_VERTICES - 1)) state_next = S_IDLE;
            S_IDLE:  if (s_tvalid) state_next = S_DEC;
            S_DEC:
            begin
                case (func_reg)
                    FUNC_ADD:   state_next = (ok_a && ok_b && !arc_full) ? S_ADD1 : S_DONE;
                    FUNC_RUN:   state_next = S_CLR;
                    FUNC_QUERY: state_next = (ok_a && res_valid_reg) ? S_QRD : S_DONE;
                    default:    state_next = S_DONE;
                endcase
            end
            S_ADD1:  state_next = S_ADD2;
            S_ADD2:  state_next = S_ADD3;
            S_ADD3:  state_next = S_DONE;
            S_QRD:   state_next = S_DONE;
            S_CLR:   if (idx_reg == VAW'(MAX_VERTICES - 1)) state_next = S_RROOT;
            S_RROOT: state_next = (root_reg > {1'b0, eff_cnt}) ? S_DONE : S_RCHK;
            S_RCHK:  state_next = (disc_rdata != '0) ? S_RROOT : S_STEP;
            S_STEP:
            begin
                if (have_arc)
                    state_next = S_ARC;
                else if (cur_p_reg == '0)
                    state_next = S_RCUT;
                else
                    state_next = S_POP;
            end
            S_ARC:   state_next = tgt_ok ? S_VISIT : S_STEP;
            S_VISIT: state_next = S_STEP;
            S_RCUT:  state_next = S_RROOT;
            S_POP:   state_next = S_STEP;
            S_DONE:  if (!m_valid_reg || m_tready) state_next = S_IDLE;
            default: state_next = S_INIT;
        endcase
    end

    // memory controls
    always_comb
    begin
        head_we = 1'b0; head_waddr = '0; head_wdata = '0; head_raddr = '0;
        arc_we = 1'b0; arc_waddr = '0; next_wdata = '0; tgt_wdata = '0; arc_raddr = '0;
        disc_we = 1'b0; disc_waddr = '0; disc_wdata = '0; disc_raddr = '0;
        low_we = 1'b0; low_waddr = '0; low_wdata = '0; low_raddr = '0;
        cut_we = 1'b0; cut_waddr = '0; cut_wdata = 1'b0; cut_raddr = '0;
        stk_we = 1'b0; stk_waddr = '0; stk_wdata = '0; stk_raddr = '0;
        case (state_reg)
            S_INIT:
            begin
                head_we    = 1'b1;
                head_waddr = idx_reg;
            end
            S_DEC:
            begin
                head_raddr = vidx(va_reg);
                cut_raddr  = vidx(va_reg);
            end
            S_ADD1:
            begin
                arc_we     = 1'b1;
                arc_waddr  = AIW'(used_reg);
                next_wdata = head_rdata;
                tgt_wdata  = vb_reg;
                head_we    = 1'b1;
                head_waddr = vidx(va_reg);
                head_wdata = used_reg + 1'b1;
            end
            S_ADD2:  head_raddr = vidx(vb_reg);
            S_ADD3:
            begin
                arc_we     = 1'b1;
                arc_waddr  = AIW'(used_reg);
                next_wdata = head_rdata;
                tgt_wdata  = va_reg;
                head_we    = 1'b1;
                head_waddr = vidx(vb_reg);
                head_wdata = used_reg + 1'b1;
            end
            S_CLR:
            begin
                disc_we   = 1'b1;
                disc_waddr = idx_reg;
                cut_we    = 1'b1;
                cut_waddr = idx_reg;
            end
            S_RROOT:
            begin
                disc_raddr = vidx(root_reg[VID_W-1:0]);
                head_raddr = vidx(root_reg[VID_W-1:0]);
            end
            S_RCHK:
            begin
                disc_we    = (disc_rdata == '0);
                disc_waddr = vidx(root_reg[VID_W-1:0]);
                disc_wdata = t_next;
            end
            S_STEP:
            begin
                arc_raddr = AIW'(cur_a_reg - 1'b1);
                stk_raddr = VAW'(sp_reg - SPW'(2));
                low_raddr = vidx(cur_p_reg);
                if (cur_p_reg == '0)
                begin
                    cut_raddr = vidx(cur_v_reg);
                end
                else
                begin
                    cut_raddr  = vidx(cur_p_reg);
                    disc_raddr = vidx(cur_p_reg);
                end
            end
            S_ARC:
            begin
                disc_raddr = vidx(tgt_rdata);
                head_raddr = vidx(tgt_rdata);
            end
            S_VISIT:
            begin
                if (disc_rdata == '0)
                begin
                    stk_we     = 1'b1;
                    stk_waddr  = VAW'(sp_reg - 1'b1);
                    stk_wdata  = {cur_v_reg, cur_p_reg, cur_a_reg, cur_ch_reg + 1'b1};
                    low_we     = 1'b1;
                    low_waddr  = vidx(cur_v_reg);
                    low_wdata  = cur_low_reg;
                    disc_we    = 1'b1;
                    disc_waddr = vidx(tgt_reg);
                    disc_wdata = t_next;
                end
            end
            S_RCUT:
            begin
                cut_we    = mark_root;
                cut_waddr = vidx(cur_v_reg);
                cut_wdata = 1'b1;
            end
            S_POP:
            begin
                cut_we    = mark_pop;
                cut_waddr = vidx(ent_v);
                cut_wdata = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            vc_reg        <= VCOUNT_RST;
            used_reg      <= '0;
            res_valid_reg <= 1'b0;
            time_reg      <= '0;
            total_reg     <= '0;
            idx_reg       <= '0;
            sp_reg        <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wen)
            begin
                vc_reg <= cfg_wdata;
            end
            // the done state reloads the output register itself
            if (m_valid_reg && m_tready && state_reg != S_DONE)
            begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_INIT:  idx_reg <= idx_reg + 1'b1;
                S_IDLE:
                begin
                    func_reg <= s_tuser;
                    va_reg   <= s_tdata[10:0];
                    vb_reg   <= s_tdata[21:11];
                end
                S_DEC:
                begin
                    status_reg <= ST_OK;
                    iscut_reg  <= 1'b0;
                    count_reg  <= '0;
                    idx_reg    <= '0;
                    case (func_reg)
                        FUNC_ADD:
                        begin
                            if (!ok_a || !ok_b)
                                status_reg <= ST_RANGE;
                            else if (arc_full)
                                status_reg <= ST_FULL;
                        end
                        FUNC_QUERY:
                        begin
                            if (!ok_a)
                                status_reg <= ST_RANGE;
                            else if (!res_valid_reg)
                                status_reg <= ST_NOCALC;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                S_ADD1:  used_reg <= used_reg + 1'b1;
                S_ADD3:  used_reg <= used_reg + 1'b1;
                S_QRD:
                begin
                    iscut_reg <= cut_rdata;
                    count_reg <= total_reg;
                end
                S_CLR:
                begin
                    idx_reg   <= idx_reg + 1'b1;
                    time_reg  <= '0;
                    total_reg <= '0;
                    root_reg  <= (VID_W+1)'(1);
                end
                S_RROOT:
                begin
                    if (root_reg > {1'b0, eff_cnt})
                    begin
                        res_valid_reg <= 1'b1;
                        count_reg     <= total_reg;
                    end
                end
                S_RCHK:
                begin
                    if (disc_rdata != '0)
                    begin
                        root_reg <= root_reg + 1'b1;
                    end
                    else
                    begin
                        time_reg    <= t_next;
                        cur_v_reg   <= root_reg[VID_W-1:0];
                        cur_p_reg   <= '0;
                        cur_a_reg   <= head_rdata;
                        cur_ch_reg  <= '0;
                        cur_low_reg <= t_next;
                        sp_reg      <= SPW'(1);
                    end
                end
                S_STEP:
                begin
                    if (!have_arc)
                    begin
                        child_low_reg <= cur_low_reg;
                        sp_reg        <= sp_reg - 1'b1;
                    end
                end
                S_ARC:
                begin
                    cur_a_reg <= next_rdata;
                    tgt_reg   <= tgt_rdata;
                end
                S_VISIT:
                begin
                    if (disc_rdata == '0)
                    begin
                        time_reg    <= t_next;
                        cur_v_reg   <= tgt_reg;
                        cur_p_reg   <= cur_v_reg;
                        cur_a_reg   <= head_rdata;
                        cur_ch_reg  <= '0;
                        cur_low_reg <= t_next;
                        sp_reg      <= sp_reg + 1'b1;
                    end
                    else if (tgt_reg != cur_p_reg && disc_rdata < cur_low_reg)
                    begin
                        cur_low_reg <= disc_rdata;   // back edge
                    end
                end
                S_RCUT:
                begin
                    if (mark_root)
                        total_reg <= total_reg + 1'b1;
                    root_reg <= root_reg + 1'b1;
                end
                S_POP:
                begin
                    if (mark_pop)
                        total_reg <= total_reg + 1'b1;
                    cur_v_reg   <= ent_v;
                    cur_p_reg   <= ent_p;
                    cur_a_reg   <= ent_a;
                    cur_ch_reg  <= ent_ch;
                    cur_low_reg <= (child_low_reg < low_rdata) ? child_low_reg : low_rdata;
                end
                S_DONE:
                begin
                    if (!m_valid_reg || m_tready)
                    begin
                        m_valid_reg  <= 1'b1;
                        m_status_reg <= status_reg;
                        m_cut_reg    <= iscut_reg;
                        m_count_reg  <= count_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SPW'(MAX_VERTICES))
        else $error("DFS stack pointer beyond depth");

    a_used_even: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg <= PW'(ARC_CAP)) &&
        (state_reg == S_ADD2 || state_reg == S_ADD3 || !used_reg[0]))
        else $error("arc store count out of step");

    a_cuts_le_time: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= time_reg)
        else $error("more cut vertices than discovered vertices");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result issued outside done state");

endmodule
